### hdl/lob_pkg.sv
// lob_pkg: shared types and constants for the limit order book
// holds the request codes, status codes and the token passed along the cell chain
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lob_pkg;

  // number of order slots, one cell each
  localparam int unsigned ORDERS = 256;

  localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_REDUCE = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NOT_FOUND     = 2'd1,
    ST_NOT_REDUCTION = 2'd2,
    ST_POOL_FULL     = 2'd3
  } status_e;

  // request plus running book summary, moves one cell per cycle unless the chain holds
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] ref_id;
    logic [31:0] new_id;
    logic        done;
    status_e     status;
    logic        have_bid;
    logic [31:0] bid;
    logic        have_ask;
    logic [31:0] ask;
    logic [47:0] bid_total;
    logic [47:0] ask_total;
  } token_t;

endpackage

`default_nettype wire

### hdl/limit_order_book.sv
// limit_order_book: top level of the order book, a chain of slot cells
// depends on lob_pkg and lob_cell
//
// Usage: an input request (kind, side, price_ticks, quantity, order_ref) is
// taken when in_valid_i is high and in_stall_o is low. The request enters a
// head register and then walks the chain of ORDERS slot cells, one cell per
// cycle while the chain is not held. Each cell applies the request to its
// slot (the lowest free cell takes an add, the lowest cell holding the id
// takes cancel, reduce or remove) and adds its slot to the running best
// prices and side totals. The request passes the head register, then the
// ORDERS cells; the output register loads as the request leaves the last
// cell. One request is in the chain at a time: a new request is not accepted
// until the last one has left the chain.
// The result stays in the output register until out_stall_i is low; a new
// request may be accepted while it waits. If the next result reaches the end
// of the chain while the output is still stalled, the whole chain holds.
// Reset empties every slot and sets the next order id to one.
`timescale 1ns / 1ps
`default_nettype none

module limit_order_book (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  kind_i,
  input  wire         side_i,
  input  wire  [31:0] price_ticks_i,
  input  wire  [31:0] quantity_i,
  input  wire  [31:0] order_ref_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] assigned_id_o,
  output logic [31:0] top_bid_o,
  output logic [31:0] top_ask_o,
  output logic [31:0] spread_ticks_o,
  output logic [47:0] bid_total_o,
  output logic [47:0] ask_total_o
);

  lob_pkg::token_t tok [lob_pkg::ORDERS+1];
  lob_pkg::token_t head_q;
  lob_pkg::token_t head_d;
  lob_pkg::token_t head_tok;
  logic            head_vld_q;
  logic            busy_q;
  logic [31:0]     next_id_q;
  logic            adv;
  logic            accept;
  lob_pkg::token_t tail;
  lob_pkg::status_e fin_status;
  logic            add_ok;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign tail       = tok[lob_pkg::ORDERS];
  assign adv        = !(tail.valid && out_valid_o && out_stall_i);
  assign tok[0]     = head_tok;

  // chain of slot cells
  for (genvar g = 0; g < lob_pkg::ORDERS; g++) begin : g_cell
    lob_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  // final status of the request leaving the chain
  always_comb begin
    add_ok     = (tail.kind == lob_pkg::KIND_ADD) && tail.done;
    fin_status = tail.status;
    if (!tail.done) begin
      fin_status = (tail.kind == lob_pkg::KIND_ADD) ? lob_pkg::ST_POOL_FULL
                                                    : lob_pkg::ST_NOT_FOUND;
    end
  end

  // control: busy flag, head valid, next id, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      head_vld_q  <= 1'b0;
      next_id_q   <= 32'd1;
      out_valid_o <= 1'b0;
    end else begin
      if (accept) begin
        busy_q     <= 1'b1;
        head_vld_q <= 1'b1;
      end else if (adv) begin
        head_vld_q <= 1'b0;
      end
      if (tail.valid && adv) begin
        busy_q      <= 1'b0;
        out_valid_o <= 1'b1;
        if (add_ok) next_id_q <= next_id_q + 32'd1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // fresh request with an empty summary
  always_comb begin
    head_d          = '0;
    head_d.valid    = 1'b1;
    head_d.kind     = lob_pkg::kind_e'(kind_i);
    head_d.side     = side_i;
    head_d.price    = price_ticks_i;
    head_d.qty      = quantity_i;
    head_d.ref_id   = order_ref_i;
    head_d.new_id   = next_id_q;
    head_d.status   = lob_pkg::ST_OK;
  end

  // head payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_q <= head_d;
    end
  end

  // head token takes its valid from the reset register
  always_comb begin
    head_tok       = head_q;
    head_tok.valid = head_vld_q;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (tail.valid && adv) begin
      status_o      <= fin_status;
      assigned_id_o <= add_ok ? tail.new_id : 32'd0;
      top_bid_o     <= tail.bid;
      top_ask_o     <= tail.ask;
      spread_ticks_o <= (tail.bid != 32'd0 && tail.ask != 32'd0 && tail.ask >= tail.bid)
                        ? (tail.ask - tail.bid) : 32'd0;
      bid_total_o   <= tail.bid_total;
      ask_total_o   <= tail.ask_total;
    end
  end

endmodule

`default_nettype wire

### hdl/lob_cell.sv
// lob_cell: one order slot of the book chain
// applies the passing request to its slot and folds the slot into the summary
// depends on lob_pkg
`timescale 1ns / 1ps
`default_nettype none

module lob_cell (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              adv_i,
  input  lob_pkg::token_t  tok_i,
  output lob_pkg::token_t  tok_o
);

  logic        valid_q, valid_d;
  logic [31:0] id_q, id_d;
  logic        side_q, side_d;
  logic [31:0] price_q, price_d;
  logic [31:0] qty_q, qty_d;
  lob_pkg::token_t tok_d, tok_q;
  logic        tok_vld_q;
  logic        hit_add, hit_ref;
  logic [48:0] sum;

  // apply request, then fold the updated slot into the summary
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    side_d  = side_q;
    price_d = price_q;
    qty_d   = qty_q;
    tok_d   = tok_i;
    sum     = '0;
    hit_add = tok_i.valid && !tok_i.done && (tok_i.kind == lob_pkg::KIND_ADD) && !valid_q;
    hit_ref = tok_i.valid && !tok_i.done && (tok_i.kind != lob_pkg::KIND_ADD) && valid_q &&
              (id_q == tok_i.ref_id);
    if (hit_add) begin
      valid_d    = 1'b1;
      id_d       = tok_i.new_id;
      side_d     = tok_i.side;
      price_d    = tok_i.price;
      qty_d      = tok_i.qty;
      tok_d.done = 1'b1;
    end else if (hit_ref) begin
      tok_d.done = 1'b1;
      if (tok_i.kind == lob_pkg::KIND_REDUCE) begin
        if (tok_i.qty >= qty_q) begin
          tok_d.status = lob_pkg::ST_NOT_REDUCTION;
        end else if (tok_i.qty == 32'd0) begin
          valid_d = 1'b0;
        end else begin
          qty_d = tok_i.qty;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
    if (valid_d) begin
      if (!side_d) begin
        if (!tok_i.have_bid || price_d > tok_i.bid) tok_d.bid = price_d;
        tok_d.have_bid = 1'b1;
        sum = {1'b0, tok_i.bid_total} + {17'd0, qty_d};
        tok_d.bid_total = sum[48] ? lob_pkg::TOTAL_MAX : sum[47:0];
      end else begin
        if (!tok_i.have_ask || price_d < tok_i.ask) tok_d.ask = price_d;
        tok_d.have_ask = 1'b1;
        sum = {1'b0, tok_i.ask_total} + {17'd0, qty_d};
        tok_d.ask_total = sum[48] ? lob_pkg::TOTAL_MAX : sum[47:0];
      end
    end
  end

  // slot valid and token valid are control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else if (adv_i) begin
      tok_vld_q <= tok_i.valid;
      if (tok_i.valid) valid_q <= valid_d;
    end
  end

  // slot payload and token payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (tok_i.valid) begin
        id_q    <= id_d;
        side_q  <= side_d;
        price_q <= price_d;
        qty_q   <= qty_d;
      end
      tok_q <= tok_d;
    end
  end

  // outgoing token takes its valid from the reset register
  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_vld_q;
  end

endmodule

`default_nettype wire

### hdl/lob_checker.sv
// lob_checker: port-level checks for the limit order book
// watches only the top-level ports; bound to limit_order_book below
`timescale 1ns / 1ps
`default_nettype none

module lob_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  status_o,
  input wire [31:0] assigned_id_o,
  input wire [31:0] top_bid_o,
  input wire [31:0] top_ask_o,
  input wire [31:0] spread_ticks_o
);

  // one request at a time: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while chain busy");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
                                       $stable(assigned_id_o)))
    else $error("stalled result changed");

  // only a successful request carries an id
  a_id_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != lob_pkg::ST_OK) |-> (assigned_id_o == 32'd0))
    else $error("id given on failed request");

  // spread is zero when a side is empty
  a_spread_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (top_bid_o == 32'd0 || top_ask_o == 32'd0)) |->
      (spread_ticks_o == 32'd0))
    else $error("spread on empty side");

endmodule

bind limit_order_book lob_checker u_lob_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .assigned_id_o  (assigned_id_o),
  .top_bid_o      (top_bid_o),
  .top_ask_o      (top_ask_o),
  .spread_ticks_o (spread_ticks_o)
);

`default_nettype wire

### test/limit_order_book_tb.sv
// limit_order_book_tb: self-checking testbench for the limit order book
// depends on lob_pkg and limit_order_book; predicts each result from its own book copy
`timescale 1ns / 1ps

module limit_order_book_tb;

  typedef struct packed {
    logic            drain;
    lob_pkg::kind_e  kind;
    logic            side;
    logic [31:0]     price;
    logic [31:0]     qty;
    logic [31:0]     ref_id;
  } order_req_t;

  typedef struct packed {
    lob_pkg::status_e status;
    logic [31:0]      assigned_id;
    logic [31:0]      bid;
    logic [31:0]      ask;
    logic [31:0]      spread;
    logic [47:0]      bid_total;
    logic [47:0]      ask_total;
  } book_view_t;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic        side_i = 1'b0;
  logic [31:0] price_ticks_i = '0;
  logic [31:0] quantity_i = '0;
  logic [31:0] order_ref_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] assigned_id_o;
  logic [31:0] top_bid_o;
  logic [31:0] top_ask_o;
  logic [31:0] spread_ticks_o;
  logic [47:0] bid_total_o;
  logic [47:0] ask_total_o;

  limit_order_book DUT (.*);

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: a private copy of the book
  logic        bk_valid [lob_pkg::ORDERS];
  logic [31:0] bk_id    [lob_pkg::ORDERS];
  logic        bk_side  [lob_pkg::ORDERS];
  logic [31:0] bk_price [lob_pkg::ORDERS];
  logic [31:0] bk_qty   [lob_pkg::ORDERS];
  logic [31:0] bk_next_id;

  order_req_t pending_reqs[$];
  book_view_t expected_views[$];
  int unsigned mismatches = 0;
  int unsigned reqs_sent = 0;
  int unsigned views_seen = 0;
  int unsigned full_seen = 0;
  bit          stim_done = 1'b0;

  function automatic logic [47:0] sat_total(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? lob_pkg::TOTAL_MAX : s[47:0];
  endfunction

  // apply one request to the book copy and return the summary it gives
  function automatic book_view_t apply_request(order_req_t r);
    book_view_t v;
    int slot;
    logic hb, ha;
    v = '0;
    v.status = lob_pkg::ST_OK;
    slot = -1;
    hb = 1'b0;
    ha = 1'b0;
    if (r.kind == lob_pkg::KIND_ADD) begin
      for (int i = 0; i < lob_pkg::ORDERS; i++)
        if (slot < 0 && !bk_valid[i]) slot = i;
      if (slot < 0) begin
        v.status = lob_pkg::ST_POOL_FULL;
      end else begin
        bk_valid[slot] = 1'b1;
        bk_id[slot] = bk_next_id;
        bk_side[slot] = r.side;
        bk_price[slot] = r.price;
        bk_qty[slot] = r.qty;
        v.assigned_id = bk_next_id;
        bk_next_id = bk_next_id + 32'd1;
      end
    end else begin
      for (int i = 0; i < lob_pkg::ORDERS; i++)
        if (slot < 0 && bk_valid[i] && bk_id[i] == r.ref_id) slot = i;
      if (slot < 0) v.status = lob_pkg::ST_NOT_FOUND;
      else if (r.kind == lob_pkg::KIND_REDUCE) begin
        if (r.qty >= bk_qty[slot]) v.status = lob_pkg::ST_NOT_REDUCTION;
        else if (r.qty == 0) bk_valid[slot] = 1'b0;
        else bk_qty[slot] = r.qty;
      end else bk_valid[slot] = 1'b0;
    end
    // top of book and side totals
    for (int i = 0; i < lob_pkg::ORDERS; i++) begin
      if (bk_valid[i]) begin
        if (!bk_side[i]) begin
          if (!hb || bk_price[i] > v.bid) v.bid = bk_price[i];
          hb = 1'b1;
          v.bid_total = sat_total(v.bid_total, bk_qty[i]);
        end else begin
          if (!ha || bk_price[i] < v.ask) v.ask = bk_price[i];
          ha = 1'b1;
          v.ask_total = sat_total(v.ask_total, bk_qty[i]);
        end
      end
    end
    if (v.bid != 0 && v.ask != 0 && v.ask >= v.bid) v.spread = v.ask - v.bid;
    return v;
  endfunction

  task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH result %0d %s: got %0h want %0h", views_seen, field, got, want);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // driver: feeds pending requests, predicts on acceptance
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    order_req_t r;
    logic       drive;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      drive = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        r.drain = 1'b0;
        r.kind = lob_pkg::kind_e'(kind_i);
        r.side = side_i;
        r.price = price_ticks_i;
        r.qty = quantity_i;
        r.ref_id = order_ref_i;
        expected_views.insert(expected_views.size(), apply_request(r));
        reqs_sent++;
        drive = 1'b0;
        send_gap = pick_gap();
      end
      if (!drive) begin
        if (send_gap > 0) send_gap--;
        else if (pending_reqs.size() > 0 &&
                 !(pending_reqs[0].drain && expected_views.size() > 0)) begin
          r = pending_reqs.pop_front();
          kind_i <= r.kind;
          side_i <= r.side;
          price_ticks_i <= r.price;
          quantity_i <= r.qty;
          order_ref_i <= r.ref_id;
          drive = 1'b1;
        end
      end
      in_valid_i <= drive;
    end
  end

  // monitor: compares results, drives random output stalls
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    book_view_t want;
    logic       stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected result, status", {46'd0, status_o}, 48'd0);
        end else begin
          want = expected_views.pop_front();
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (assigned_id_o != want.assigned_id)
            report_mismatch("assigned_id", assigned_id_o, want.assigned_id);
          if (top_bid_o != want.bid) report_mismatch("top_bid", top_bid_o, want.bid);
          if (top_ask_o != want.ask) report_mismatch("top_ask", top_ask_o, want.ask);
          if (spread_ticks_o != want.spread)
            report_mismatch("spread", spread_ticks_o, want.spread);
          if (bid_total_o != want.bid_total)
            report_mismatch("bid_total", bid_total_o, want.bid_total);
          if (ask_total_o != want.ask_total)
            report_mismatch("ask_total", ask_total_o, want.ask_total);
          if (want.status == lob_pkg::ST_POOL_FULL) full_seen++;
        end
        views_seen++;
      end
      // one long hold-off partway through, one stall-free stretch, otherwise short random stalls
      if (!hold_done && views_seen == 600) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (views_seen > 300 && views_seen < 400) stall = 1'b0;
      else stall = ($urandom_range(0, 99) < 10) ||
                   ($urandom_range(0, 399) == 0);
      out_stall_i <= stall;
    end
  end

  // watchdog on cycles with no handshake
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else if (rst_ni && !stim_done) idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_req(logic drain, lob_pkg::kind_e k, logic s, logic [31:0] p,
                           logic [31:0] q, logic [31:0] id);
    order_req_t r;
    r.drain = drain;
    r.kind = k;
    r.side = s;
    r.price = p;
    r.qty = q;
    r.ref_id = id;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // random request; refs mostly point near recently issued ids
  task automatic queue_random(ref int unsigned ids_given, input int unsigned add_pct);
    lob_pkg::kind_e k;
    logic [31:0]    id;
    logic [31:0]    q;
    logic [31:0]    p;
    if ($urandom_range(0, 99) < add_pct) k = lob_pkg::KIND_ADD;
    else k = lob_pkg::kind_e'($urandom_range(1, 3));
    if ($urandom_range(0, 9) == 0) id = $urandom;
    else id = ids_given - $urandom_range(0, 40);
    if ($urandom_range(0, 9) == 0) p = $urandom;
    else p = 32'd1000 + $urandom_range(0, 200);
    q = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    if (k == lob_pkg::KIND_ADD) ids_given++;
    queue_req(1'b0, k, 1'($urandom_range(0, 1)), p, q, id);
  endtask

  initial begin
    int unsigned ids_given;
    for (int i = 0; i < lob_pkg::ORDERS; i++) begin
      bk_valid[i] = 1'b0;
      bk_id[i] = '0;
      bk_side[i] = 1'b0;
      bk_price[i] = '0;
      bk_qty[i] = '0;
    end
    bk_next_id = 32'd1;

    // directed: extremes, each kind, each status but pool full
    queue_req(1'b0, lob_pkg::KIND_ADD, 1'b0, 32'd1, 32'd0, 32'd0);            // id 1
    queue_req(1'b0, lob_pkg::KIND_ADD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'd0);                                                        // id 2
    queue_req(1'b0, lob_pkg::KIND_ADD, 1'b0, 32'd200, 32'd50, 32'hFFFF_FFFF); // id 3
    queue_req(1'b0, lob_pkg::KIND_ADD, 1'b1, 32'd100, 32'd10, 32'd0);  // id 4, crossed
    queue_req(1'b0, lob_pkg::KIND_ADD, 1'b0, 32'd0, 32'd7, 32'd0);     // id 5, zero price
    queue_req(1'b0, lob_pkg::KIND_ADD, 1'b1, 32'd0, 32'd9, 32'd0);     // id 6
    queue_req(1'b0, lob_pkg::KIND_CANCEL, 1'b0, 32'd0, 32'd0, 32'd6);
    queue_req(1'b0, lob_pkg::KIND_CANCEL, 1'b0, 32'd0, 32'd0, 32'd4);  // uncross
    queue_req(1'b0, lob_pkg::KIND_REDUCE, 1'b0, 32'd0, 32'd50, 32'd3); // equal
    queue_req(1'b0, lob_pkg::KIND_REDUCE, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd3); // larger
    queue_req(1'b0, lob_pkg::KIND_REDUCE, 1'b0, 32'd0, 32'd5, 32'd3);
    queue_req(1'b0, lob_pkg::KIND_REDUCE, 1'b0, 32'd0, 32'd0, 32'd3);  // to zero
    queue_req(1'b0, lob_pkg::KIND_REMOVE, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd2);
    queue_req(1'b0, lob_pkg::KIND_REMOVE, 1'b0, 32'd0, 32'd0, 32'd2);  // gone
    queue_req(1'b0, lob_pkg::KIND_CANCEL, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    queue_req(1'b0, lob_pkg::KIND_REDUCE, 1'b0, 32'd0, 32'd0, 32'h8000_0000);
    queue_req(1'b1, lob_pkg::KIND_CANCEL, 1'b0, 32'd0, 32'd0, 32'd1);
    queue_req(1'b0, lob_pkg::KIND_CANCEL, 1'b0, 32'd0, 32'd0, 32'd5);
    ids_given = 7;

    // random mix
    for (int i = 0; i < 500; i++) queue_random(ids_given, 45);
    // fill the pool past full, then drain it with a mix that favors removal
    queue_req(1'b1, lob_pkg::KIND_ADD, 1'b0, 32'd900, 32'd1, 32'd0);
    ids_given++;
    for (int i = 0; i < 300; i++) queue_random(ids_given, 100);
    for (int i = 0; i < 600; i++) queue_random(ids_given, 20);
    queue_req(1'b1, lob_pkg::KIND_ADD, 1'b1, 32'd1100, 32'd3, 32'd0);
    ids_given++;
    for (int i = 0; i < 30; i++) queue_random(ids_given, 50);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_valid_i && expected_views.size() == 0);
    repeat (lob_pkg::ORDERS + 20) @(posedge clk_i);
    stim_done = 1'b1;
    if (expected_views.size() != 0) begin
      report_mismatch("results never arrived", 48'(expected_views.size()), 48'd0);
    end
    $display("sent %0d requests, checked %0d results, %0d pool-full rejects",
             reqs_sent, views_seen, full_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### limit_order_book.f
hdl/lob_pkg.sv
hdl/lob_cell.sv
hdl/limit_order_book.sv
hdl/lob_checker.sv
test/limit_order_book_tb.sv
